@@ rtl/crs_pkg.sv @@
package crs_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_COMPUTE = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    CFG_DIMENSIONS = 3'd0,
    CFG_SIZE_X     = 3'd1,
    CFG_SIZE_Y     = 3'd2,
    CFG_SIZE_Z     = 3'd3,
    CFG_INV_SQ_X   = 3'd4,
    CFG_INV_SQ_Y   = 3'd5,
    CFG_INV_SQ_Z   = 3'd6,
    CFG_VOL_WEIGHT = 3'd7
  } cfg_e;

  typedef enum logic [1:0] {
    SHIFT_8  = 2'd0,
    SHIFT_9  = 2'd1,
    SHIFT_16 = 2'd2
  } shift_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIZE,
    ST_COUNT,
    ST_CHECK,
    ST_RD_C,
    ST_RD_M,
    ST_RD_P,
    ST_DIFF,
    ST_AXIS_WAIT,
    ST_SUM,
    ST_SCALE_WAIT,
    ST_ENERGY,
    ST_ENERGY_WAIT,
    ST_NEXT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [63:0] b;
    shift_e      shift;
    logic        wide_cap;
  } mul_req_t;

  localparam logic [12:0] SIZE_ONE = 13'd1;
  localparam logic [31:0] Q16_ONE  = 32'h0001_0000;

endpackage

@@ rtl/crs_ram.sv @@
module crs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/crs_mul.sv @@
module crs_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crs_pkg::mul_req_t req_i,
  output logic              done_o,
  output logic [63:0]       q_o
);
  import crs_pkg::*;

  logic        busy_q, busy_d;
  logic [1:0]  step_q, step_d;
  logic        done_q, done_d;
  logic [31:0] a_q;
  logic [63:0] b_q;
  shift_e      shift_q;
  logic        wide_q;
  logic [63:0] p0_q, p1_q;
  logic [96:0] sum_q;
  logic [63:0] res_q;
  logic [63:0] prod;
  logic [96:0] rnd, sum_d;
  logic [88:0] shifted, cap;
  logic [63:0] result;

  assign prod = a_q * ((step_q == 2'd0) ? b_q[31:0] : b_q[63:32]);

  always_comb begin
    unique case (shift_q)
      SHIFT_8: begin
        rnd     = 97'd128;
        shifted = 89'(sum_q >> 8);
      end
      SHIFT_9: begin
        rnd     = 97'd256;
        shifted = 89'(sum_q >> 9);
      end
      SHIFT_16: begin
        rnd     = 97'd32768;
        shifted = 89'(sum_q >> 16);
      end
      default: begin
        rnd     = 97'd0;
        shifted = 89'(sum_q);
      end
    endcase
    sum_d  = {1'b0, p1_q, 32'b0} + {33'b0, p0_q} + rnd;
    cap    = wide_q ? (89'd1 << 63) : (89'd1 << 61);
    result = (shifted > cap) ? cap[63:0] : shifted[63:0];
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = 2'd0;
    end else if (busy_q) begin
      step_d = step_q + 2'd1;
      if (step_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q     <= req_i.a;
      b_q     <= req_i.b;
      shift_q <= req_i.shift;
      wide_q  <= req_i.wide_cap;
    end else if (busy_q) begin
      unique case (step_q)
        2'd0: p0_q  <= prod;
        2'd1: p1_q  <= prod;
        2'd2: sum_q <= sum_d;
        2'd3: res_q <= result;
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign q_o    = res_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("multiplier started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("multiplier done without work");
  a_done_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !wide_q) |-> (res_q <= (64'd1 << 61))) else $error("result above cap");
`endif

endmodule

@@ rtl/curvature_regularizer_stencil_top.sv @@
// Curvature regularizer on a 2D or 3D vector field held in on-chip stores.
// Input stream: tuser carries the function (load, read gradient, compute),
// tdata carries the element index and the signed Q16.16 sample.
// A load transaction writes one sample and returns nothing; one is taken per
// cycle while the block is idle and no read result waits. A read transaction
// returns one Q24.24 gradient element through the gradient store's read
// register and the output register, and reads are also taken one per cycle
// while the output is not stalled. A compute transaction runs two
// clamped-border Laplacian passes over all components and a scale and energy
// step (no pass if the grid is empty or too large), then returns one
// transaction with the energy and a status flag. Each element goes through
// the single read port of each store and the shared 32x32 multiplier.
// Output results sit in a register; a stalled receiver holds it, and a second
// read result waits in the gradient store's read register, after which the
// input stops taking transactions. The user must write configuration through
// the plain write port only while the block is idle; it is not enforced.
// Reset clears the configuration to its defaults, the energy to zero and the
// gradient fill count to zero, so all gradient reads return zero until a
// compute has written them; no clearing pass runs.
module curvature_regularizer_stencil_top #(
  parameter int GRID_POINTS    = 4096,
  parameter int MAX_COMPONENTS = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [47:0]  s_axis_tdata_i,  // element_index, sample_value
  input  logic [1:0]   s_axis_tuser_i,  // func
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [111:0] m_axis_tdata_o,  // gradient_value, energy
  output logic [0:0]   m_axis_tuser_o,  // status
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_wdata_i
);
  import crs_pkg::*;

  localparam int STORE_DEPTH = MAX_COMPONENTS * GRID_POINTS;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic signed [63:0] POS48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] NEG48 = 64'shFFFF_8000_0000_0000;
  localparam logic signed [63:0] POS64 = 64'sh7FFF_FFFF_FFFF_FFFF;

  function automatic logic signed [63:0] sat48(input logic signed [63:0] v);
    if (v > POS48) begin
      return POS48;
    end else if (v < NEG48) begin
      return NEG48;
    end
    return v;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      return a[63] ? ~POS64 : POS64;
    end
    return s;
  endfunction

  logic [1:0]  dim_q;
  logic [12:0] size_x_q, size_y_q, size_z_q;
  logic [31:0] isx_q, isy_q, isz_q, vw_q;

  state_e state_q, state_d;

  logic [13:0] in_idx;
  logic [31:0] in_sample;
  func_e       in_func;
  logic        in_range, in_fill, in_acc;
  logic [AW-1:0] in_addr;
  logic        load_we, rd_grad, cmp_start;

  logic        out_valid_q, out_status_q, out_ready, emit;
  logic [47:0] out_grad_q;
  logic [63:0] out_energy_q;
  logic        p1_valid_q, p1_zero_q, p1_adv;
  logic signed [63:0] energy_q;
  logic [CW-1:0] fill_q;

  logic        three, too_large, pass2_q, status_q;
  logic [1:0]  ax_q, ax_last;
  logic [12:0] i_q, j_q, k_q, sz_eff;
  logic [AW-1:0] at_q, last_q, sx_a, plane_a, step, minus_addr, plus_addr, rd_addr;
  logic [CW-1:0] total_q, points_a, total_w;
  logic [25:0] plane_q;
  logic [38:0] points_q;
  logic signed [51:0] c_q, m_q, src_val, d_w;
  logic        dneg_q, sneg_q, eneg_q, lo_edge, hi_edge;
  logic signed [63:0] s_q, s_sat, term, g_w, e_w, acc_q;
  logic signed [47:0] g_q;
  logic signed [31:0] x_q;
  logic [31:0] w_ax, x_mag;

  logic        sample_re, lap_re, lap_we, grad_we;
  logic [31:0] sample_rdata;
  logic [47:0] lap_rdata, grad_rdata;
  mul_req_t    mul_req;
  logic        mul_done;
  logic [63:0] mul_q;

  assign in_idx    = s_axis_tdata_i[13:0];
  assign in_sample = s_axis_tdata_i[45:14];
  assign in_func   = func_e'(s_axis_tuser_i);
  assign in_range  = 32'(in_idx) < 32'(STORE_DEPTH);
  assign in_fill   = 32'(in_idx) < 32'(fill_q);
  assign in_addr   = AW'(in_idx);

  assign out_ready = !out_valid_q || m_axis_tready_i;
  assign p1_adv    = p1_valid_q && out_ready;
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!p1_valid_q || p1_adv);
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign load_we   = in_acc && (in_func == FUNC_LOAD) && in_range;
  assign rd_grad   = in_acc && (in_func == FUNC_READ);
  assign cmp_start = in_acc && (in_func == FUNC_COMPUTE);
  assign emit      = (state_q == ST_DONE) && !p1_valid_q && out_ready;

  assign three     = dim_q == 2'd3;
  assign sz_eff    = three ? size_z_q : SIZE_ONE;
  assign ax_last   = three ? 2'd2 : 2'd1;
  assign too_large = (points_q > 39'(GRID_POINTS)) || (three && (MAX_COMPONENTS < 3));
  assign points_a  = CW'(points_q);
  assign total_w   = (points_a << 1) + (three ? points_a : '0);
  assign sx_a      = AW'(size_x_q);
  assign plane_a   = AW'(plane_q);

  always_comb begin
    unique case (ax_q)
      2'd0: begin
        step = AW'(1);
        lo_edge = i_q == '0;
        hi_edge = i_q == size_x_q - SIZE_ONE;
        w_ax = isx_q;
      end
      2'd1: begin
        step = sx_a;
        lo_edge = j_q == '0;
        hi_edge = j_q == size_y_q - SIZE_ONE;
        w_ax = isy_q;
      end
      default: begin
        step = plane_a;
        lo_edge = k_q == '0;
        hi_edge = k_q == sz_eff - SIZE_ONE;
        w_ax = isz_q;
      end
    endcase
    minus_addr = lo_edge ? at_q : at_q - step;
    plus_addr  = hi_edge ? at_q : at_q + step;
  end

  assign src_val = pass2_q ? {{4{lap_rdata[47]}}, lap_rdata}
                           : {{20{sample_rdata[31]}}, sample_rdata};
  assign d_w     = m_q + src_val - (c_q <<< 1);
  assign term    = dneg_q ? -$signed(mul_q) : $signed(mul_q);
  assign s_sat   = sat48(s_q);
  assign g_w     = sat48(sneg_q ? -$signed(mul_q) : $signed(mul_q));
  assign x_mag   = x_q[31] ? 32'(-x_q) : 32'(x_q);
  assign e_w     = eneg_q ? -$signed(mul_q) : (mul_q[63] ? POS64 : $signed(mul_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:        if (cmp_start) state_d = ST_SIZE;
      ST_SIZE:        state_d = ST_COUNT;
      ST_COUNT:       state_d = ST_CHECK;
      ST_CHECK:       state_d = (too_large || (points_q == '0)) ? ST_DONE : ST_RD_C;
      ST_RD_C:        state_d = ST_RD_M;
      ST_RD_M:        state_d = ST_RD_P;
      ST_RD_P:        state_d = ST_DIFF;
      ST_DIFF:        state_d = ST_AXIS_WAIT;
      ST_AXIS_WAIT: begin
        if (mul_done) state_d = (ax_q == ax_last) ? ST_SUM : ST_RD_M;
      end
      ST_SUM:         state_d = pass2_q ? ST_SCALE_WAIT : ST_NEXT;
      ST_SCALE_WAIT:  if (mul_done) state_d = ST_ENERGY;
      ST_ENERGY:      state_d = ST_ENERGY_WAIT;
      ST_ENERGY_WAIT: if (mul_done) state_d = ST_NEXT;
      ST_NEXT:        state_d = ((at_q == last_q) && pass2_q) ? ST_DONE : ST_RD_C;
      ST_DONE:        if (emit) state_d = ST_IDLE;
      default:        state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr   = at_q;
    sample_re = 1'b0;
    lap_re    = 1'b0;
    lap_we    = 1'b0;
    grad_we   = 1'b0;
    mul_req   = '{start: 1'b0, a: '0, b: '0, shift: SHIFT_8, wide_cap: 1'b0};
    unique case (state_q)
      ST_RD_C, ST_RD_M, ST_RD_P: begin
        if (state_q == ST_RD_M) rd_addr = minus_addr;
        if (state_q == ST_RD_P) rd_addr = plus_addr;
        sample_re = !pass2_q;
        lap_re    = pass2_q;
      end
      ST_DIFF: begin
        mul_req.start = 1'b1;
        mul_req.a     = w_ax;
        mul_req.b     = d_w[51] ? {12'b0, -d_w} : {12'b0, d_w};
        mul_req.shift = pass2_q ? SHIFT_16 : SHIFT_8;
      end
      ST_SUM: begin
        if (pass2_q) begin
          sample_re     = 1'b1;
          mul_req.start = 1'b1;
          mul_req.a     = vw_q;
          mul_req.b     = s_sat[63] ? -s_sat : s_sat;
          mul_req.shift = SHIFT_16;
        end else begin
          lap_we = 1'b1;
        end
      end
      ST_SCALE_WAIT: grad_we = mul_done;
      ST_ENERGY: begin
        mul_req.start    = 1'b1;
        mul_req.a        = x_mag;
        mul_req.b        = g_q[47] ? {16'b0, -g_q} : {16'b0, g_q};
        mul_req.shift    = SHIFT_9;
        mul_req.wide_cap = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dim_q       <= 2'd2;
      size_x_q    <= 13'd64;
      size_y_q    <= 13'd64;
      size_z_q    <= SIZE_ONE;
      isx_q       <= Q16_ONE;
      isy_q       <= Q16_ONE;
      isz_q       <= Q16_ONE;
      vw_q        <= Q16_ONE;
      out_valid_q <= 1'b0;
      p1_valid_q  <= 1'b0;
      energy_q    <= '0;
      fill_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_DIMENSIONS: dim_q    <= cfg_wdata_i[1:0];
          CFG_SIZE_X:     size_x_q <= cfg_wdata_i[12:0];
          CFG_SIZE_Y:     size_y_q <= cfg_wdata_i[12:0];
          CFG_SIZE_Z:     size_z_q <= cfg_wdata_i[12:0];
          CFG_INV_SQ_X:   isx_q    <= cfg_wdata_i;
          CFG_INV_SQ_Y:   isy_q    <= cfg_wdata_i;
          CFG_INV_SQ_Z:   isz_q    <= cfg_wdata_i;
          CFG_VOL_WEIGHT: vw_q     <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (rd_grad) begin
        p1_valid_q <= 1'b1;
      end else if (p1_adv) begin
        p1_valid_q <= 1'b0;
      end
      if (p1_adv || emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (emit && !status_q) begin
        energy_q <= acc_q;
        if (total_q > fill_q) fill_q <= total_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_grad) p1_zero_q <= !in_fill;
    if (p1_adv) begin
      out_grad_q   <= p1_zero_q ? '0 : grad_rdata;
      out_energy_q <= energy_q;
      out_status_q <= 1'b0;
    end else if (emit) begin
      out_grad_q   <= '0;
      out_energy_q <= status_q ? energy_q : acc_q;
      out_status_q <= status_q;
    end
    unique case (state_q)
      ST_SIZE:  plane_q  <= size_x_q * size_y_q;
      ST_COUNT: points_q <= plane_q * sz_eff;
      ST_CHECK: begin
        status_q <= too_large;
        acc_q    <= '0;
        total_q  <= total_w;
        last_q   <= AW'(total_w - CW'(1));
        pass2_q  <= 1'b0;
        at_q     <= '0;
        i_q      <= '0;
        j_q      <= '0;
        k_q      <= '0;
      end
      ST_RD_C: begin
        ax_q <= '0;
        s_q  <= '0;
      end
      ST_RD_M: if (ax_q == 2'd0) c_q <= src_val;
      ST_RD_P: m_q <= src_val;
      ST_DIFF: dneg_q <= d_w[51];
      ST_AXIS_WAIT: begin
        if (mul_done) begin
          s_q  <= s_q + term;
          ax_q <= ax_q + 2'd1;
        end
      end
      ST_SUM: sneg_q <= s_sat[63];
      ST_SCALE_WAIT: begin
        if (mul_done) begin
          g_q <= g_w[47:0];
          x_q <= sample_rdata;
        end
      end
      ST_ENERGY: eneg_q <= g_q[47] != x_q[31];
      ST_ENERGY_WAIT: if (mul_done) acc_q <= sat_add(acc_q, e_w);
      ST_NEXT: begin
        if (at_q == last_q) begin
          pass2_q <= 1'b1;
          at_q    <= '0;
          i_q     <= '0;
          j_q     <= '0;
          k_q     <= '0;
        end else begin
          at_q <= at_q + AW'(1);
          if (i_q == size_x_q - SIZE_ONE) begin
            i_q <= '0;
            if (j_q == size_y_q - SIZE_ONE) begin
              j_q <= '0;
              k_q <= (k_q == sz_eff - SIZE_ONE) ? '0 : k_q + SIZE_ONE;
            end else begin
              j_q <= j_q + SIZE_ONE;
            end
          end else begin
            i_q <= i_q + SIZE_ONE;
          end
        end
      end
      default: ;
    endcase
  end

  crs_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (in_addr),
    .wdata_i (in_sample),
    .re_i    (sample_re),
    .raddr_i (rd_addr),
    .rdata_o (sample_rdata)
  );

  crs_ram #(.WIDTH(48), .DEPTH(STORE_DEPTH)) u_lap_ram (
    .clk_i   (clk_i),
    .we_i    (lap_we),
    .waddr_i (at_q),
    .wdata_i (s_sat[47:0]),
    .re_i    (lap_re),
    .raddr_i (rd_addr),
    .rdata_o (lap_rdata)
  );

  crs_ram #(.WIDTH(48), .DEPTH(STORE_DEPTH)) u_grad_ram (
    .clk_i   (clk_i),
    .we_i    (grad_we),
    .waddr_i (at_q),
    .wdata_i (g_w[47:0]),
    .re_i    (rd_grad),
    .raddr_i (in_addr),
    .rdata_o (grad_rdata)
  );

  crs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .q_o    (mul_q)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_energy_q, out_grad_q};
  assign m_axis_tuser_o  = out_status_q;

`ifndef SYNTHESIS
  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_start |=> (state_q == ST_SIZE)) else $error("compute did not start");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(STORE_DEPTH)) else $error("fill count beyond store");
  a_addr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_C) |-> (at_q <= last_q)) else $error("walk beyond grid");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import crs_pkg::*;

  localparam int DEPTH = 12288;
  localparam longint POS48 = 64'sd140737488355327;
  localparam longint NEG48 = -64'sd140737488355328;
  localparam longint MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint MIN64 = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic [1:0]  func;
    logic [13:0] idx;
    logic [31:0] sample;
  } stim_t;

  typedef struct {
    logic [47:0] grad;
    logic [63:0] energy;
    logic        status;
  } result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [47:0]  s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [111:0] m_axis_tdata_o;
  logic [0:0]   m_axis_tuser_o;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_wdata_i = '0;

  curvature_regularizer_stencil_top u_dut (.*);

  always #5 clk_i = ~clk_i;

  stim_t   pending_q[$];
  result_t expected_q[$];
  int      errors = 0;
  int      accepted = 0;
  int      checked = 0;
  int      computes = 0;

  longint sample_mem[DEPTH];
  longint lap_mem[DEPTH];
  longint grad_mem[DEPTH];
  longint energy_acc = 0;
  logic [1:0]  dims_r = 2;
  logic [12:0] sx_r = 64, sy_r = 64, sz_r = 1;
  logic [31:0] wx_r = Q16_ONE, wy_r = Q16_ONE, wz_r = Q16_ONE, vw_r = Q16_ONE;

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint unsigned mul_round(logic [31:0] a, longint unsigned b, int sh,
                                                longint unsigned cap);
    logic [127:0] p;
    p = {96'd0, a} * {64'd0, b};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > {64'd0, cap}) return cap;
    return p[63:0];
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint clip48(longint v);
    return v > POS48 ? POS48 : (v < NEG48 ? NEG48 : v);
  endfunction

  function automatic longint axis_term(logic [31:0] w, longint m, longint p, longint c, int sh);
    longint d;
    longint r;
    d = m + p - 2 * c;
    r = longint'(mul_round(w, magn(d), sh, 64'd1 << 61));
    return d < 0 ? -r : r;
  endfunction

  function automatic longint src_at(bit second, longint unsigned a);
    return second ? lap_mem[a] : sample_mem[a];
  endfunction

  task automatic laplace_pass(bit second, longint unsigned base, bit three,
                              longint unsigned sx, longint unsigned sy, longint unsigned sz);
    longint unsigned plane, at, il, ir, jl, jr, kl, kr;
    longint c, s;
    int sh;
    sh = second ? 16 : 8;
    plane = sx * sy;
    for (longint unsigned k = 0; k < sz; k++)
      for (longint unsigned j = 0; j < sy; j++)
        for (longint unsigned i = 0; i < sx; i++) begin
          at = base + i + j * sx + k * plane;
          c = src_at(second, at);
          il = i ? i - 1 : 0;
          ir = i + 1 < sx ? i + 1 : i;
          jl = j ? j - 1 : 0;
          jr = j + 1 < sy ? j + 1 : j;
          s = axis_term(wx_r, src_at(second, at - i + il), src_at(second, at - i + ir), c, sh);
          s += axis_term(wy_r, src_at(second, at - j * sx + jl * sx),
                         src_at(second, at - j * sx + jr * sx), c, sh);
          if (three) begin
            kl = k ? k - 1 : 0;
            kr = k + 1 < sz ? k + 1 : k;
            s += axis_term(wz_r, src_at(second, at - k * plane + kl * plane),
                           src_at(second, at - k * plane + kr * plane), c, sh);
          end
          if (second) grad_mem[at] = clip48(s);
          else lap_mem[at] = clip48(s);
        end
  endtask

  function automatic longint unsigned grid_points();
    return longint'(sx_r) * longint'(sy_r) * (dims_r == 3 ? longint'(sz_r) : 1);
  endfunction

  task automatic run_regularizer(output logic flag);
    bit three;
    longint unsigned comps, pts, m;
    longint g, x, e, acc;
    three = dims_r == 3;
    comps = three ? 3 : 2;
    pts = grid_points();
    acc = 0;
    flag = 1'b0;
    if (pts > 4096) begin
      flag = 1'b1;
      return;
    end
    for (longint unsigned c = 0; c < comps; c++)
      laplace_pass(0, c * pts, three, sx_r, sy_r, three ? sz_r : 1);
    for (longint unsigned c = 0; c < comps; c++)
      laplace_pass(1, c * pts, three, sx_r, sy_r, three ? sz_r : 1);
    for (longint unsigned n = 0; n < comps * pts; n++) begin
      g = grad_mem[n];
      x = sample_mem[n];
      m = mul_round(vw_r, magn(g), 16, 64'd1 << 61);
      g = clip48(g < 0 ? -longint'(m) : longint'(m));
      grad_mem[n] = g;
      m = mul_round(32'(magn(x)), magn(g), 9, 64'd1 << 63);
      if ((g < 0) != (x < 0)) e = m >= (64'd1 << 63) ? MIN64 : -longint'(m);
      else e = m > MAX64 ? MAX64 : longint'(m);
      if (e > 0 && acc > MAX64 - e) acc = MAX64;
      else if (e < 0 && acc < MIN64 - e) acc = MIN64;
      else acc = acc + e;
    end
    energy_acc = acc;
  endtask

  task automatic predict_transaction(stim_t it);
    result_t r;
    logic flag;
    r.grad = '0;
    r.status = 1'b0;
    case (it.func)
      FUNC_LOAD: begin
        if (it.idx < DEPTH) sample_mem[it.idx] = longint'(signed'(it.sample));
        return;
      end
      FUNC_READ: begin
        if (it.idx < DEPTH) r.grad = grad_mem[it.idx][47:0];
      end
      FUNC_COMPUTE: begin
        run_regularizer(flag);
        r.status = flag;
        computes++;
      end
      default: return;
    endcase
    r.energy = energy_acc;
    expected_q.push_back(r);
  endtask

  // Sender side.
  int  in_gap = 0;
  bit  in_busy_mode = 0;
  always @(posedge clk_i) begin
    stim_t it;
    logic  nv;
    nv = s_axis_tvalid_i;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      it.func = s_axis_tuser_i;
      it.idx = s_axis_tdata_i[13:0];
      it.sample = s_axis_tdata_i[45:14];
      predict_transaction(it);
      accepted++;
      nv = 1'b0;
    end
    if (!nv) begin
      if ($urandom_range(0, 99) == 0) in_busy_mode = ~in_busy_mode;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_q.size() > 0) begin
        it = pending_q.pop_front();
        s_axis_tuser_i <= it.func;
        s_axis_tdata_i <= {2'b00, it.sample, it.idx};
        nv = 1'b1;
        if (!in_busy_mode) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3: in_gap = $urandom_range(1, 3);
            4: in_gap = $urandom_range(10, 60);
            default: in_gap = 0;
          endcase
        end
      end
    end
    s_axis_tvalid_i <= nv;
  end

  // Receiver side.
  int out_gap = 0;
  always @(posedge clk_i) begin
    result_t r;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_q.size() == 0) begin
        report("result transaction with nothing expected");
      end else begin
        r = expected_q.pop_front();
        checked++;
        if (m_axis_tdata_o[47:0] !== r.grad)
          report($sformatf("gradient %h, want %h", m_axis_tdata_o[47:0], r.grad));
        if (m_axis_tdata_o[111:48] !== r.energy)
          report($sformatf("energy %h, want %h", m_axis_tdata_o[111:48], r.energy));
        if (m_axis_tuser_o[0] !== r.status)
          report($sformatf("status %b, want %b", m_axis_tuser_o[0], r.status));
      end
    end
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      case ($urandom_range(0, 24))
        0, 1, 2, 3: out_gap = $urandom_range(1, 4);
        4: out_gap = $urandom_range(15, 80);
        default: out_gap = 0;
      endcase
    end
  end

  function automatic void push_item(logic [1:0] f, logic [13:0] idx, logic [31:0] v);
    stim_t it;
    it.func = f;
    it.idx = idx;
    it.sample = v;
    pending_q.push_back(it);
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  task automatic cfg_write(cfg_e idx, logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    case (idx)
      CFG_DIMENSIONS: dims_r = v[1:0];
      CFG_SIZE_X:     sx_r = v[12:0];
      CFG_SIZE_Y:     sy_r = v[12:0];
      CFG_SIZE_Z:     sz_r = v[12:0];
      CFG_INV_SQ_X:   wx_r = v;
      CFG_INV_SQ_Y:   wy_r = v;
      CFG_INV_SQ_Z:   wz_r = v;
      default:        vw_r = v;
    endcase
  endtask

  task automatic configure(logic [31:0] d, logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                           logic [31:0] wx, logic [31:0] wy, logic [31:0] wz, logic [31:0] vw);
    cfg_write(CFG_DIMENSIONS, d);
    cfg_write(CFG_SIZE_X, sx);
    cfg_write(CFG_SIZE_Y, sy);
    cfg_write(CFG_SIZE_Z, sz);
    cfg_write(CFG_INV_SQ_X, wx);
    cfg_write(CFG_INV_SQ_Y, wy);
    cfg_write(CFG_INV_SQ_Z, wz);
    cfg_write(CFG_VOL_WEIGHT, vw);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Loads every entry that a compute under the current settings reads.
  function automatic int preload();
    longint unsigned pts;
    int total;
    pts = grid_points();
    if (pts == 0 || pts > 4096) return 0;
    total = (dims_r == 3 ? 3 : 2) * int'(pts);
    for (int n = 0; n < total; n++) push_item(FUNC_LOAD, 14'(n), rand_sample());
    return total;
  endfunction

  task automatic random_phase(int count);
    int total;
    int sel;
    total = preload();
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30)
        push_item(FUNC_LOAD, (total > 0 && sel < 26) ? 14'($urandom_range(0, total - 1))
                                                     : 14'($urandom_range(0, 16383)),
                  rand_sample());
      else if (sel < 88)
        push_item(FUNC_READ, (total > 0 && sel < 80) ? 14'($urandom_range(0, total - 1))
                                                     : 14'($urandom_range(0, 16383)),
                  $urandom);
      else if (sel < 97)
        push_item(FUNC_COMPUTE, 14'($urandom_range(0, 16383)), $urandom);
      else
        push_item(2'd3, 14'($urandom_range(0, 16383)), $urandom);
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reads before any compute see an all-zero gradient store.
    push_item(FUNC_READ, 14'd0, 32'h0);
    push_item(FUNC_READ, 14'd12287, 32'hFFFF_FFFF);
    push_item(FUNC_READ, 14'd12288, 32'h0);
    push_item(FUNC_READ, 14'h3FFF, 32'h0);
    push_item(FUNC_LOAD, 14'h3FFF, 32'h7FFF_FFFF);
    push_item(FUNC_LOAD, 14'd12288, 32'h8000_0000);
    push_item(2'd3, 14'h3FFF, 32'hFFFF_FFFF);
    drain();

    configure(3, 2, 3, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int n = 0; n < 36; n++)
      push_item(FUNC_LOAD, 14'(n), n[0] ? 32'h7FFF_FFFF : 32'h8000_0000);
    push_item(FUNC_COMPUTE, 14'd0, 32'h0);
    push_item(FUNC_READ, 14'd0, 32'h0);
    push_item(FUNC_READ, 14'd35, 32'h0);
    push_item(FUNC_READ, 14'd12287, 32'h0);
    drain();

    // Too many grid points: nothing changes and the old energy comes back.
    configure(2, 8191, 1, 1, Q16_ONE, Q16_ONE, Q16_ONE, Q16_ONE);
    push_item(FUNC_COMPUTE, 14'd0, 32'h0);
    push_item(FUNC_READ, 14'd5, 32'h0);
    drain();
    configure(3, 4096, 1, 2, 0, 0, 0, 0);
    push_item(FUNC_COMPUTE, 14'd0, 32'h0);
    drain();
    // Empty grid.
    configure(2, 0, 4096, 0, 0, 0, 0, 0);
    push_item(FUNC_COMPUTE, 14'd0, 32'h0);
    drain();
    configure(0, 1, 1, 8191, Q16_ONE, 0, 32'hFFFF_FFFF, Q16_ONE);
    random_phase(20);
    configure(1, 3, 4, 5, 0, 0, 0, 32'hFFFF_FFFF);
    random_phase(20);

    for (int p = 0; p < 5; p++) begin
      configure($urandom_range(0, 3), $urandom_range(1, 5), $urandom_range(1, 5),
                $urandom_range(1, 4), rand_weight(), rand_weight(), rand_weight(),
                rand_weight());
      random_phase(50);
    end

    $display("run covered %0d input transactions, %0d results checked, %0d computes",
             accepted, checked, computes);
    if (errors == 0) $display("PASS curvature_regularizer_stencil_top");
    else $display("FAIL curvature_regularizer_stencil_top");
    $finish;
  end

  initial begin
    #40ms;
    $display("FAIL curvature_regularizer_stencil_top");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/crs_pkg.sv
rtl/crs_ram.sv
rtl/crs_mul.sv
rtl/curvature_regularizer_stencil_top.sv
sim/tb.sv
